>>> rtl/rlpc_pkg.sv
// Shared constants and register codes for the radial lens point corrector.
`default_nettype none
package rlpc_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int AREA_W         = 13;
    localparam int STR_W          = 17;
    localparam int STR_FRAC       = 16;
    localparam logic [STR_W-1:0] STR_ONE = 17'h10000;
    localparam int C2_W           = 27;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X      = 3'd0,
        REG_CENTER_Y      = 3'd1,
        REG_AREA_WIDTH    = 3'd2,
        REG_AREA_HEIGHT   = 3'd3,
        REG_LENS_STRENGTH = 3'd4
    } cfg_reg_t;
endpackage
`default_nettype wire

>>> rtl/rlpc_if.sv
// Point and result stream interfaces for the radial lens point corrector.
`default_nettype none
interface rlpc_point_if #(parameter int COORD_BITS = rlpc_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface rlpc_adj_if #(parameter int COORD_BITS = rlpc_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] adjusted_x;
    logic signed [COORD_BITS-1:0] adjusted_y;
    modport source (output valid, output adjusted_x, output adjusted_y, input ready);
    modport sink   (input valid, input adjusted_x, input adjusted_y, output ready);
endinterface
`default_nettype wire

>>> rtl/radial_lens_point_correct_top.sv
// Radial lens point corrector: fully pipelined, one point per clock.
// Each point beat passes these stages from acceptance to result: three
// front stages (offset, squares, radius compare), 2*FRAC_BITS restoring divide
// stages for radius^2/corner^2, FRAC_BITS square-root stages, then factor,
// scale and output stages. A new beat is taken every cycle; the whole pipeline
// holds when the result register is full and not taken. Configuration must be
// written while the pipeline is empty.
`default_nettype none
module radial_lens_point_correct_top #(
    parameter int COORD_BITS = rlpc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rlpc_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rlpc_point_if.sink                      point_in,
    rlpc_adj_if.source                      adj_out,
    input  logic                            cfg_we,
    input  logic [rlpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [((COORD_BITS > rlpc_pkg::STR_W) ? COORD_BITS : rlpc_pkg::STR_W)-1:0] cfg_data
);
    import rlpc_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int NDIV = 2 * F;
    localparam int QW   = 2 * F;
    localparam int RW   = C2_W + 1;
    localparam int SQW  = 2 * CB + 2;
    localparam int N4W  = 2 * CB + 5;
    localparam int PW   = STR_W + F + 1;
    localparam int PMW  = CB + F + 2;
    localparam int DIV0 = 3;
    localparam int SQ0  = DIV0 + NDIV;
    localparam int FAC  = SQ0 + F;
    localparam int MUL  = FAC + 1;
    localparam int OUTS = MUL + 1;
    localparam int NST  = OUTS + 1;

    typedef struct packed {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic                 sx;
        logic                 sy;
        logic [CB:0]          ax;
        logic [CB:0]          ay;
        logic                 byp;
        logic                 sat;
    } pl_t;

    // configuration
    logic signed [CB-1:0] center_x_reg, center_y_reg;
    logic [AREA_W-1:0]    area_width_reg, area_height_reg;
    logic [STR_W-1:0]     lens_strength_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            area_width_reg    <= '0;
            area_height_reg   <= '0;
            lens_strength_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:      center_x_reg      <= cfg_data[CB-1:0];
                REG_CENTER_Y:      center_y_reg      <= cfg_data[CB-1:0];
                REG_AREA_WIDTH:    area_width_reg    <= cfg_data[AREA_W-1:0];
                REG_AREA_HEIGHT:   area_height_reg   <= cfg_data[AREA_W-1:0];
                REG_LENS_STRENGTH: lens_strength_reg <= cfg_data[STR_W-1:0];
                default: ;
            endcase
        end
    end

    logic [STR_W-1:0]    s_cl;
    logic [AREA_W-1:0]   w2, h2;
    logic [2*AREA_W-1:0] wsq, hsq;
    logic [C2_W-1:0]     c2;

    assign s_cl = (lens_strength_reg > STR_ONE) ? STR_ONE : lens_strength_reg;
    assign w2   = (area_width_reg  < AREA_W'(2)) ? AREA_W'(2) : area_width_reg;
    assign h2   = (area_height_reg < AREA_W'(2)) ? AREA_W'(2) : area_height_reg;
    assign wsq  = w2 * w2;
    assign hsq  = h2 * h2;
    assign c2   = C2_W'({1'b0, wsq} + {1'b0, hsq});

    // pipeline control: every stage advances together
    logic           en;
    logic [NST-1:0] vld_reg;
    pl_t            pl_reg [NST];

    assign en             = !vld_reg[NST-1] || adj_out.ready;
    assign point_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], point_in.valid};
    end

    // stage 0: offset from centre and its magnitude
    logic signed [CB:0] dx, dy;
    pl_t                pl0;

    always_comb
    begin
        dx         = (CB+1)'(point_in.point_x) - (CB+1)'(center_x_reg);
        dy         = (CB+1)'(point_in.point_y) - (CB+1)'(center_y_reg);
        pl0.px     = point_in.point_x;
        pl0.py     = point_in.point_y;
        pl0.sx     = dx[CB];
        pl0.sy     = dy[CB];
        pl0.ax     = dx[CB] ? (CB+1)'(-dx) : dx;
        pl0.ay     = dy[CB] ? (CB+1)'(-dy) : dy;
        pl0.byp    = (s_cl == '0) || (area_width_reg == '0) || (area_height_reg == '0)
                     || ((dx == '0) && (dy == '0));
        pl0.sat    = 1'b0;
    end

    // stage 1 squares, stage 2 radius^2 against corner^2
    logic [SQW-1:0] sqx_reg, sqy_reg;
    logic [N4W-1:0] n4;
    logic           sat2;
    logic [RW-1:0]  rem0_reg;
    pl_t            pl2;

    assign n4   = N4W'({1'b0, sqx_reg} + {1'b0, sqy_reg}) << 2;
    assign sat2 = n4 >= N4W'(c2);

    always_comb
    begin
        pl2     = pl_reg[1];
        pl2.sat = sat2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg[0] <= pl0;
            pl_reg[1] <= pl_reg[0];
            pl_reg[2] <= pl2;
            for (int k = 3; k < NST; k++)
                pl_reg[k] <= pl_reg[k-1];
            sqx_reg  <= pl_reg[0].ax * pl_reg[0].ax;
            sqy_reg  <= pl_reg[0].ay * pl_reg[0].ay;
            rem0_reg <= sat2 ? '0 : n4[RW-1:0];
        end
    end

    // restoring divide, one quotient bit per stage
    logic [RW-1:0] rem_reg [NDIV];
    logic [QW-1:0] q_reg   [NDIV];

    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        logic [RW-1:0] rin, r2;
        logic [QW-1:0] qin;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rin = rem0_reg;
            assign qin = '0;
        end
        else
        begin : g_next
            assign rin = rem_reg[k-1];
            assign qin = q_reg[k-1];
        end

        assign r2 = rin << 1;
        assign ge = r2 >= RW'(c2);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (r2 - RW'(c2)) : r2;
                q_reg[k]   <= {qin[QW-2:0], ge};
            end
        end
    end

    // square root, one result bit per stage
    logic [QW-1:0] sqq_reg [F];
    logic [QW:0]   res_reg [F];

    for (genvar i = 0; i < F; i++)
    begin : g_sqrt
        logic [QW-1:0] qin;
        logic [QW:0]   rin, bitv, trial;

        if (i == 0)
        begin : g_first
            assign qin = q_reg[NDIV-1];
            assign rin = '0;
        end
        else
        begin : g_next
            assign qin = sqq_reg[i-1];
            assign rin = res_reg[i-1];
        end

        assign bitv  = (QW+1)'(1) << (QW - 2 - 2 * i);
        assign trial = rin + bitv;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({1'b0, qin} >= trial)
                begin
                    sqq_reg[i] <= qin - trial[QW-1:0];
                    res_reg[i] <= (rin >> 1) + bitv;
                end
                else
                begin
                    sqq_reg[i] <= qin;
                    res_reg[i] <= rin >> 1;
                end
            end
        end
    end

    // factor = one - round(strength * (one - t))
    localparam logic [F:0] ONE = (F+1)'(1) << F;
    logic [F:0]    tt, omt, red;
    logic [PW-1:0] sprod;
    logic [F:0]    factor_reg;

    assign tt    = pl_reg[FAC-1].sat ? ONE : {1'b0, res_reg[F-1][F-1:0]};
    assign omt   = ONE - tt;
    assign sprod = PW'(s_cl) * PW'(omt);
    assign red   = (F+1)'((sprod + (PW'(1) << (STR_FRAC - 1))) >> STR_FRAC);

    // scaled magnitudes, rounded half up on the magnitude
    logic [PMW-1:0] pmx, pmy;
    logic [CB:0]    mx_reg, my_reg;

    assign pmx = PMW'(pl_reg[MUL-1].ax) * PMW'(factor_reg);
    assign pmy = PMW'(pl_reg[MUL-1].ay) * PMW'(factor_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            factor_reg <= ONE - red;
            mx_reg     <= (CB+1)'((pmx + (PMW'(1) << (F - 1))) >> F);
            my_reg     <= (CB+1)'((pmy + (PMW'(1) << (F - 1))) >> F);
        end
    end

    // add back to the centre and saturate
    localparam logic signed [CB+1:0] HI = (CB+2)'((1 << (CB - 1)) - 1);
    localparam logic signed [CB+1:0] LO = -HI - (CB+2)'(1);
    logic signed [CB+1:0] sumx, sumy;
    logic signed [CB-1:0] resx, resy;
    logic signed [CB-1:0] adj_x_reg, adj_y_reg;

    always_comb
    begin
        sumx = pl_reg[OUTS-1].sx ? ((CB+2)'(center_x_reg) - $signed({1'b0, mx_reg}))
                                 : ((CB+2)'(center_x_reg) + $signed({1'b0, mx_reg}));
        sumy = pl_reg[OUTS-1].sy ? ((CB+2)'(center_y_reg) - $signed({1'b0, my_reg}))
                                 : ((CB+2)'(center_y_reg) + $signed({1'b0, my_reg}));
        resx = (sumx > HI) ? HI[CB-1:0] : ((sumx < LO) ? LO[CB-1:0] : sumx[CB-1:0]);
        resy = (sumy > HI) ? HI[CB-1:0] : ((sumy < LO) ? LO[CB-1:0] : sumy[CB-1:0]);
        if (pl_reg[OUTS-1].byp)
        begin
            resx = pl_reg[OUTS-1].px;
            resy = pl_reg[OUTS-1].py;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adj_x_reg <= resx;
            adj_y_reg <= resy;
        end
    end

    assign adj_out.valid      = vld_reg[NST-1];
    assign adj_out.adjusted_x = adj_x_reg;
    assign adj_out.adjusted_y = adj_y_reg;

    a_bypass_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NST-1] && pl_reg[NST-1].byp) |->
        (adj_x_reg == pl_reg[NST-1].px && adj_y_reg == pl_reg[NST-1].py))
        else $error("bypassed point altered");

    a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[MUL-1] |-> (factor_reg <= ONE))
        else $error("lens factor above one");

    a_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[OUTS-1] |-> (mx_reg <= pl_reg[OUTS-1].ax && my_reg <= pl_reg[OUTS-1].ay))
        else $error("scaled offset grew");
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Testbench for the radial lens point corrector: stimulus, prediction and result checks.
`timescale 1ns / 1ps
module tb_top;
    import rlpc_pkg::*;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int LATENCY = 6 + 3 * FB;
    localparam int DATA_W = (CB > STR_W) ? CB : STR_W;
    localparam int CYCLE_LIMIT = 1000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    rlpc_point_if #(.COORD_BITS(CB)) point_ch ();
    rlpc_adj_if #(.COORD_BITS(CB)) adj_ch ();

    radial_lens_point_correct_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .point_in(point_ch.sink),
        .adj_out(adj_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // lens settings as the block should hold them
    logic signed [CB-1:0] lens_cx, lens_cy;
    logic [AREA_W-1:0] lens_w, lens_h;
    logic [STR_W-1:0] lens_s;

    logic signed [CB-1:0] want_x[$];
    logic signed [CB-1:0] want_y[$];
    int errors = 0;
    int cycles = 0;
    int long_hold = 0;
    bit stall_on = 1;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt(logic [63:0] q);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > q)
            b = b >> 2;
        while (b != 0)
        begin
            if (q >= res + b)
            begin
                q = q - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [CB-1:0] clamp_coord(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[CB-1:0];
    endfunction

    function automatic longint pull_offset(longint d, longint unsigned f);
        longint unsigned mag;
        longint unsigned m;
        mag = (d < 0) ? -d : d;
        m = (mag * f + (64'd1 << (FB - 1))) >> FB;
        return (d < 0) ? -longint'(m) : longint'(m);
    endfunction

    task automatic lens_correct(input logic signed [CB-1:0] px, input logic signed [CB-1:0] py,
                                output logic signed [CB-1:0] ax,
                                output logic signed [CB-1:0] ay);
        longint dx, dy;
        longint unsigned s, n4, w2, h2, c2, t, q, rem, f, one;
        one = 64'd1 << FB;
        s = (lens_s > STR_ONE) ? STR_ONE : lens_s;
        dx = longint'(px) - longint'(lens_cx);
        dy = longint'(py) - longint'(lens_cy);
        ax = px;
        ay = py;
        if (s == 0 || lens_w == 0 || lens_h == 0 || (dx == 0 && dy == 0))
            return;
        n4 = 4 * (dx * dx + dy * dy);
        w2 = (lens_w < 2) ? 2 : lens_w;
        h2 = (lens_h < 2) ? 2 : lens_h;
        c2 = w2 * w2 + h2 * h2;
        if (n4 >= c2)
            t = one;
        else
        begin
            rem = n4;
            q = 0;
            for (int i = 0; i < 2 * FB; i++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= c2)
                begin
                    rem = rem - c2;
                    q = q | 1;
                end
            end
            t = isqrt(q);
            if (t > one)
                t = one;
        end
        f = one - ((s * (one - t) + (64'd1 << 15)) >> 16);
        ax = clamp_coord(longint'(lens_cx) + pull_offset(dx, f));
        ay = clamp_coord(longint'(lens_cy) + pull_offset(dy, f));
    endtask

    // called at a falling edge; cfg_we is low again before the task returns
    task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            REG_CENTER_X: lens_cx = val[CB-1:0];
            REG_CENTER_Y: lens_cy = val[CB-1:0];
            REG_AREA_WIDTH: lens_w = val[AREA_W-1:0];
            REG_AREA_HEIGHT: lens_h = val[AREA_W-1:0];
            REG_LENS_STRENGTH: lens_s = val[STR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_lens(input int cx, input int cy, input int w, input int h,
                            input int s);
        wait (want_x.size() == 0);
        @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        write_reg(REG_CENTER_X, DATA_W'(cx));
        write_reg(REG_CENTER_Y, DATA_W'(cy));
        write_reg(REG_AREA_WIDTH, DATA_W'(w));
        write_reg(REG_AREA_HEIGHT, DATA_W'(h));
        write_reg(REG_LENS_STRENGTH, DATA_W'(s));
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a falling edge; returns at a falling edge after the beat
    task automatic send_point(input logic signed [CB-1:0] px, input logic signed [CB-1:0] py,
                              input bit gaps);
        logic signed [CB-1:0] ex, ey;
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            point_ch.valid <= 0;
            repeat (g) @(negedge clk);
        end
        lens_correct(px, py, ex, ey);
        point_ch.valid <= 1;
        point_ch.point_x <= px;
        point_ch.point_y <= py;
        do
            @(posedge clk);
        while (!point_ch.ready);
        want_x.push_back(ex);
        want_y.push_back(ey);
        @(negedge clk);
    endtask

    task automatic end_burst();
        point_ch.valid <= 0;
    endtask

    function automatic logic signed [CB-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if (r < 3)
            return $urandom();
        return lens_cx + $signed(16'($urandom_range(0, 2 * (lens_w + 8)))) - lens_w - 8;
    endfunction

    // receiver: random stalls when enabled, plus one long hold when asked
    always @(negedge clk)
    begin
        if (!rst_n)
            adj_ch.ready <= 0;
        else if (long_hold > 0)
        begin
            adj_ch.ready <= 0;
            long_hold <= long_hold - 1;
        end
        else if (!stall_on)
            adj_ch.ready <= 1;
        else
            adj_ch.ready <= ($urandom_range(0, 99) < 70) ? 1'b1 :
                            ($urandom_range(0, 19) == 0 ? 1'b0 : ($urandom_range(0, 1) == 1));
    end

    always @(posedge clk)
    begin
        if (rst_n && adj_ch.valid && adj_ch.ready)
        begin
            if (want_x.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d", $time,
                         adj_ch.adjusted_x, adj_ch.adjusted_y);
                errors++;
            end
            else
            begin
                if (adj_ch.adjusted_x !== want_x[0])
                begin
                    $display("%0t: adjusted_x expected %0d got %0d", $time,
                             want_x[0], adj_ch.adjusted_x);
                    errors++;
                end
                if (adj_ch.adjusted_y !== want_y[0])
                begin
                    $display("%0t: adjusted_y expected %0d got %0d", $time,
                             want_y[0], adj_ch.adjusted_y);
                    errors++;
                end
                void'(want_x.pop_front());
                void'(want_y.pop_front());
            end
        end
    end

    task automatic test_pass_through();
        set_lens(0, 0, 0, 0, 0);
        send_point(16'sh7fff, 16'sh8000, 0);
        send_point(16'sh8000, 16'sh7fff, 0);
        end_burst();
        set_lens(100, -50, 0, 200, 65536);
        send_point(120, -40, 0);
        end_burst();
        set_lens(100, -50, 300, 0, 65536);
        send_point(90, -60, 0);
        send_point(100, -50, 0);
        end_burst();
        set_lens(100, -50, 300, 200, 65536);
        send_point(100, -50, 0);
        end_burst();
    endtask

    task automatic test_extremes();
        set_lens(-32768, 32767, 8191, 8191, 65536);
        send_point(16'sh7fff, 16'sh8000, 0);
        send_point(-32767, 32766, 0);
        send_point(0, 0, 0);
        end_burst();
        set_lens(32767, -32768, 1, 1, 131071);
        send_point(32766, -32767, 0);
        send_point(32767, -32767, 0);
        send_point(16'sh8000, 16'sh7fff, 0);
        end_burst();
        set_lens(5, 5, 40, 30, 32768);
        send_point(6, 5, 0);
        send_point(-5, 15, 0);
        send_point(25, 20, 0);
        send_point(-20, -10, 0);
        send_point(5, 20, 0);
        end_burst();
        // unknown register index is dropped
        wait (want_x.size() == 0);
        @(negedge clk);
        write_reg(cfg_reg_t'(3'd7), '1);
        write_reg(cfg_reg_t'(3'd5), '0);
        send_point(7, 3, 0);
        end_burst();
    endtask

    task automatic test_random(input int n, input bit hold);
        int w, h;
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 300);
        h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 300);
        set_lens($urandom_range(0, 65535), $urandom_range(0, 65535), w, h,
                 ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071) :
                 $urandom_range(0, 65536));
        if (hold)
            long_hold <= 150;
        stall_on = !hold && ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(), rand_coord(), !hold && stall_on);
        end_burst();
        stall_on = 1;
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        point_ch.valid = 0;
        point_ch.point_x = 0;
        point_ch.point_y = 0;
        lens_cx = 0;
        lens_cy = 0;
        lens_w = 0;
        lens_h = 0;
        lens_s = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_pass_through();
        test_extremes();
        test_random(150, 1);
        for (int k = 0; k < 20; k++)
            test_random(100, 0);
        wait (want_x.size() == 0);
        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0 && want_x.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
